// ===== hw/rtl/qkpd_pkg.sv =====
// shared types and constants for the knob to pwm duty controller
// no dependencies; used by every module of the block
`default_nettype none
package qkpd_pkg;

	localparam int DataBits  = 16;
	localparam int StepBits  = 8;
	localparam int CountBits = 16;
	localparam int CmpBits   = (CountBits > DataBits) ? CountBits : DataBits;
	localparam int CfgIdxBits = 8;

	typedef logic [DataBits-1:0]   data_t;
	typedef logic [StepBits-1:0]   steps_t;
	typedef logic [CountBits-1:0]  count_t;
	typedef logic [CmpBits-1:0]    cmp_t;

	typedef enum logic [CfgIdxBits-1:0] {
		CFG_PWM_PERIOD = 8'd0,
		CFG_DUTY_STEPS = 8'd1
	} cfg_idx_t;

	localparam data_t  PeriodReset = 16'd1000;
	localparam steps_t StepsReset  = 8'd20;

	typedef struct packed {
		logic lower;
		logic raise;
	} detent_evt_t;

endpackage
`default_nettype wire

// ===== hw/rtl/quadrature_knob_pwm_duty.sv =====
// top level of the rotary knob to pwm duty controller
// depends on qkpd_pkg, qkpd_div and qkpd_detent
// Each input transaction is one timer tick carrying encoder pins A and B, and gives
// exactly one result transaction: pwm level, down/up detent leds and the duty after
// the tick. A result reaches the output register once its tick has passed through the
// bit-serial divider working out pwm_period / duty_steps, the divider finishing, the
// duty update and the hand-off. A new tick is taken only in the idle state after the
// hand-off, so the block works on one tick at a time. A result still waiting for
// out_ready at hand-off holds the block until it is taken. in_ready is low while a tick
// is being worked on; the next tick is taken while an earlier result still waits in the
// output register.
// Registers: index 0 pwm_period (reset 1000), index 1 duty_steps (reset 20, 0 acts
// as 1); other indices are ignored. Write them only while the block is idle.
`default_nettype none
module quadrature_knob_pwm_duty (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               pin_a,
	input  wire logic               pin_b,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    pwm_out,
	output logic                    down_led,
	output logic                    up_led,
	output qkpd_pkg::data_t         duty_now,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [qkpd_pkg::CfgIdxBits-1:0] cfg_index,
	input  wire qkpd_pkg::data_t    cfg_data
);
	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_DIV  = 2'd1,
		S_UPD  = 2'd2,
		S_SEND = 2'd3
	} state_t;

	state_t                 state_q;
	qkpd_pkg::data_t        period_q;
	qkpd_pkg::steps_t       steps_q;
	qkpd_pkg::count_t       tick_q;
	qkpd_pkg::data_t        duty_q;
	logic                   down_q;
	logic                   up_q;
	logic                   pin_a_q;
	logic                   pin_b_q;
	logic                   res_pwm_q;

	logic                   out_valid_q;
	logic                   pwm_out_q;
	logic                   down_led_q;
	logic                   up_led_q;
	qkpd_pkg::data_t        duty_now_q;

	logic                   accept;
	logic                   div_done;
	qkpd_pkg::data_t        step;
	qkpd_pkg::steps_t       divisor;
	qkpd_pkg::detent_evt_t  evt;
	qkpd_pkg::data_t        dclamp;
	qkpd_pkg::data_t        duty_d;
	qkpd_pkg::count_t       tick_plus;
	qkpd_pkg::count_t       tick_d;
	logic                   pwm_d;
	logic                   slot_free;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign divisor   = (steps_q == '0) ? qkpd_pkg::steps_t'(1) : steps_q;
	assign slot_free = !out_valid_q || out_ready;

	qkpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (period_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (step)
	);

	qkpd_detent u_detent (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (state_q == S_UPD),
		.a      (pin_a_q),
		.b      (pin_b_q),
		.evt    (evt)
	);

	always_comb begin
		dclamp = (duty_q > period_q) ? period_q : duty_q;
		pwm_d  = qkpd_pkg::cmp_t'(dclamp) > qkpd_pkg::cmp_t'(tick_q);
		duty_d = dclamp;
		if (evt.lower) begin
			if (dclamp >= step)
				duty_d = dclamp - step;
		end else if (evt.raise) begin
			if (dclamp <= period_q - step)
				duty_d = dclamp + step;
		end
		tick_plus = tick_q + qkpd_pkg::count_t'(1);
		if (qkpd_pkg::cmp_t'(tick_plus) >= qkpd_pkg::cmp_t'(period_q)
				|| qkpd_pkg::cmp_t'(tick_q) >= qkpd_pkg::cmp_t'(period_q))
			tick_d = '0;
		else
			tick_d = tick_plus;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pin_a_q <= pin_a;
			pin_b_q <= pin_b;
		end
		if (state_q == S_UPD)
			res_pwm_q <= pwm_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			period_q    <= qkpd_pkg::PeriodReset;
			steps_q     <= qkpd_pkg::StepsReset;
			tick_q      <= '0;
			duty_q      <= '0;
			down_q      <= 1'b0;
			up_q        <= 1'b0;
			out_valid_q <= 1'b0;
			pwm_out_q   <= 1'b0;
			down_led_q  <= 1'b0;
			up_led_q    <= 1'b0;
			duty_now_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == qkpd_pkg::CFG_PWM_PERIOD)
					period_q <= cfg_data;
				else if (cfg_index == qkpd_pkg::CFG_DUTY_STEPS)
					steps_q <= cfg_data[qkpd_pkg::StepBits-1:0];
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_UPD;
				end
				S_UPD: begin
					duty_q <= duty_d;
					tick_q <= tick_d;
					if (evt.lower) begin
						down_q <= 1'b1;
						up_q   <= 1'b0;
					end else if (evt.raise) begin
						down_q <= 1'b0;
						up_q   <= 1'b1;
					end
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						pwm_out_q   <= res_pwm_q;
						down_led_q  <= down_q;
						up_led_q    <= up_q;
						duty_now_q  <= duty_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pwm_out   = pwm_out_q;
	assign down_led  = down_led_q;
	assign up_led    = up_led_q;
	assign duty_now  = duty_now_q;

`ifndef SYNTHESIS
	a_leds_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(down_led && up_led))
		else $error("down and up leds both lit");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("ready again straight after a tick was accepted");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide phase");

	a_one_result_per_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEND && slot_free) |=> (out_valid && in_ready))
		else $error("result hand-off did not complete");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/qkpd_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on qkpd_pkg
`default_nettype none
module qkpd_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire qkpd_pkg::data_t  dividend,
	input  wire qkpd_pkg::steps_t divisor,
	output logic                  done,
	output qkpd_pkg::data_t       quotient
);
	localparam int IterBits = $clog2(qkpd_pkg::DataBits);

	logic                       busy_q;
	logic                       done_q;
	logic [IterBits-1:0]        cnt_q;
	qkpd_pkg::data_t            quot_q;
	qkpd_pkg::steps_t           rem_q;
	qkpd_pkg::steps_t           dsr_q;
	logic [qkpd_pkg::StepBits:0] trial;
	logic [qkpd_pkg::StepBits:0] diff;
	logic                       ge;

	assign trial = {rem_q, quot_q[qkpd_pkg::DataBits-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + IterBits'(1);
				if (cnt_q == IterBits'(qkpd_pkg::DataBits - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[qkpd_pkg::DataBits-2:0], ge};
			rem_q  <= ge ? diff[qkpd_pkg::StepBits-1:0] : trial[qkpd_pkg::StepBits-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;
endmodule
`default_nettype wire

// ===== hw/rtl/qkpd_detent.sv =====
// quadrature detent tracker: phase register and detent events
// depends on qkpd_pkg
`default_nettype none
module qkpd_detent (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               a,
	input  wire logic               b,
	output qkpd_pkg::detent_evt_t   evt
);
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HALF_B = 3'd1,
		PH_FULL_B = 3'd2,
		PH_HALF_A = 3'd3,
		PH_FULL_A = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	phase_t phase_q;
	phase_t phase_d;

	assign evt.lower = a && !b && (phase_q == PH_FULL_B);
	assign evt.raise = !a && b && (phase_q == PH_FULL_A);

	always_comb begin
		phase_d = phase_q;
		case ({a, b})
			2'b11: phase_d = PH_IDLE;
			2'b10: begin
				if (phase_q == PH_FULL_B)
					phase_d = PH_DONE;
				else if (phase_q == PH_IDLE)
					phase_d = PH_HALF_A;
			end
			2'b01: begin
				if (phase_q == PH_FULL_A)
					phase_d = PH_DONE;
				else if (phase_q == PH_IDLE)
					phase_d = PH_HALF_B;
			end
			2'b00: begin
				if (phase_q == PH_HALF_B)
					phase_d = PH_FULL_B;
				else if (phase_q == PH_HALF_A)
					phase_d = PH_FULL_A;
			end
			default: phase_d = phase_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= PH_IDLE;
		else if (adv)
			phase_q <= phase_d;
	end
endmodule
`default_nettype wire
